@@ sv/hcbd_pkg.sv @@
// shared types, codes and helper functions of the chunked body decoder
`default_nettype none

package hcbd_pkg;

    localparam logic [3:0] PH_LEAD    = 4'd0;
    localparam logic [3:0] PH_DIGITS  = 4'd1;
    localparam logic [3:0] PH_EXT     = 4'd2;
    localparam logic [3:0] PH_DATA    = 4'd3;
    localparam logic [3:0] PH_SKIP1   = 4'd4;
    localparam logic [3:0] PH_SKIP2   = 4'd5;
    localparam logic [3:0] PH_TRAILER = 4'd6;
    localparam logic [3:0] PH_DONE    = 4'd7;
    localparam logic [3:0] PH_TOOBIG  = 4'd8;

    localparam logic [2:0] ST_FRAME    = 3'd0;
    localparam logic [2:0] ST_PAYLOAD  = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_TOOLARGE = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_SP  = 8'h20;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic [31:0] payload_total;
    } t_result;

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SP) || (b == CHAR_TAB) || (b == CHAR_LF) ||
               (b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_CR);
    endfunction

endpackage

`default_nettype wire

@@ sv/hcbd_if.sv @@
// valid/ready channel interfaces for raw input bytes and decoded results
`default_nettype none

interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_new;

    modport source (output valid, output data_byte, output start_new, input ready);
    modport sink   (input valid, input data_byte, input start_new, output ready);
endinterface

interface hcbd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic [31:0] payload_total;

    modport source (output valid, output status, output payload_byte,
                    output payload_total, input ready);
    modport sink   (input valid, input status, input payload_byte,
                    input payload_total, output ready);
endinterface

`default_nettype wire

@@ sv/hcbd_core.sv @@
// decoder state registers and single pass next state and result logic
`default_nettype none

module hcbd_core
    import hcbd_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_start_new,
    input  wire logic [31:0] i_max_body_size,
    output t_result          o_result
);

    localparam int W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    logic [3:0]            r_phase, n_phase;
    logic                  r_cr, n_cr;
    logic [COUNT_BITS-1:0] r_chunk, n_chunk;
    logic [COUNT_BITS-1:0] r_total, n_total;

    logic [3:0]            e_phase;
    logic                  e_cr;
    logic [COUNT_BITS-1:0] e_chunk, e_total;
    logic [4:0]            hd;
    logic [COUNT_BITS-1:0] acc, total_inc, chunk_dec;
    logic                  too_big;
    logic [W-1:0]          tot_w;
    logic [2:0]            status;
    logic [7:0]            pay;

    always_comb begin
        e_phase = i_start_new ? PH_LEAD : r_phase;
        e_cr    = i_start_new ? 1'b0 : r_cr;
        e_chunk = i_start_new ? '0 : r_chunk;
        e_total = i_start_new ? '0 : r_total;

        hd        = hex_digit(i_data_byte);
        acc       = (e_chunk[COUNT_BITS-1 -: 4] != 4'd0) ? '1
                                                          : {e_chunk[COUNT_BITS-5:0], hd[3:0]};
        total_inc = (e_total != '1) ? e_total + COUNT_BITS'(1) : e_total;
        chunk_dec = (e_chunk != '0) ? e_chunk - COUNT_BITS'(1) : e_chunk;
        too_big   = (i_max_body_size != 32'd0) && (W'(total_inc) > W'(i_max_body_size));

        n_phase = e_phase;
        n_cr    = e_cr;
        n_chunk = e_chunk;
        n_total = e_total;
        status  = ST_FRAME;
        pay     = 8'd0;

        case (e_phase)
            PH_LEAD, PH_DIGITS, PH_EXT, PH_TRAILER: begin
                if (i_data_byte == CHAR_LF && e_cr) begin
                    n_cr = 1'b0;
                    if (e_phase == PH_TRAILER) begin
                        status  = ST_COMPLETE;
                        n_phase = PH_DONE;
                    end else if (e_chunk == '0) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_cr = (i_data_byte == CHAR_CR);
                    if (e_phase == PH_LEAD) begin
                        if (hd[4]) begin
                            n_chunk = acc;
                            n_phase = PH_DIGITS;
                        end else if (!is_blank(i_data_byte)) begin
                            n_phase = PH_EXT;
                        end
                    end else if (e_phase == PH_DIGITS) begin
                        if (hd[4]) begin
                            n_chunk = acc;
                        end else begin
                            n_phase = PH_EXT;
                        end
                    end
                end
            end
            PH_DATA: begin
                n_total = total_inc;
                n_chunk = chunk_dec;
                if (too_big) begin
                    status  = ST_TOOLARGE;
                    n_phase = PH_TOOBIG;
                end else begin
                    status = ST_PAYLOAD;
                    pay    = i_data_byte;
                    if (chunk_dec == '0) begin
                        n_phase = PH_SKIP1;
                    end
                end
            end
            PH_SKIP1: begin
                n_phase = PH_SKIP2;
            end
            PH_SKIP2: begin
                n_phase = PH_LEAD;
                n_cr    = 1'b0;
                n_chunk = '0;
            end
            default: begin
                status = ST_IGNORED;
            end
        endcase

        tot_w                  = W'(n_total);
        o_result.status        = status;
        o_result.payload_byte  = pay;
        o_result.payload_total = (tot_w > W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : tot_w[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_cr    <= 1'b0;
            r_chunk <= '0;
            r_total <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cr    <= n_cr;
            r_chunk <= n_chunk;
            r_total <= n_total;
        end
    end

endmodule

`default_nettype wire

@@ sv/hcbd_outbuf.sv @@
// result register with a skid stage so one more input is taken during an output stall
`default_nettype none

module hcbd_outbuf
    import hcbd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  t_result     i_result,
    output logic        o_ready,
    hcbd_out_if.source  o_out
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_free;

    assign o_ready  = !r_skid_valid;
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_load;
            end
        end else if (i_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_load) begin
                r_out <= i_result;
            end
        end else if (i_load) begin
            r_skid <= i_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.payload_total = r_out.payload_total;

endmodule

`default_nettype wire

@@ sv/http_chunked_body_decoder.sv @@
// top level of the chunked body decoder: config register, core and result buffer
//
//  channel  dir  handshake                    transaction
//  i_in     in   valid/ready                  one raw body byte, restart flag
//  o_out    out  valid/ready                  status, payload byte, running total
//  i_cfg    in   i_cfg_valid/o_cfg_ready      max_body_size write
//
// one byte per cycle while i_in.ready is high; each result is registered in the result buffer
// state and result are produced in a single registered pass, no iteration
// synchronous active low reset returns to the size line with zero counts
// a two entry result buffer lets one byte in while a result waits; i_in.ready
// drops only once both entries are full
`default_nettype none

module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    hcbd_in_if.sink          i_in,
    hcbd_out_if.source       o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_max_body_size
);

    logic [31:0] r_max_body_size;
    logic        buf_ready;
    logic        accept;
    t_result     result;

    assign o_cfg_ready = 1'b1;
    assign i_in.ready  = buf_ready;
    assign accept      = i_in.valid && buf_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body_size <= 32'd0;
        end else if (i_cfg_valid) begin
            r_max_body_size <= i_cfg_max_body_size;
        end
    end

    hcbd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_in.data_byte),
        .i_start_new     (i_in.start_new),
        .i_max_body_size (r_max_body_size),
        .o_result        (result)
    );

    hcbd_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (result),
        .o_ready  (buf_ready),
        .o_out    (o_out)
    );

`ifndef NO_ASSERTIONS
    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with no pending result");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> o_out.valid)
        else $error("accepted byte produced no result");

    a_payload_only_on_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_PAYLOAD) |-> (o_out.payload_byte == 8'd0))
        else $error("payload byte set on a non-payload result");
`endif

endmodule

`default_nettype wire

@@ sim/tb_http_chunked_body_decoder.sv @@
// testbench for the chunked body decoder: a directed body and random chunked bodies checked byte by byte
module tb_http_chunked_body_decoder
    import hcbd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASE_ITEMS = 325;
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Z     = 8'h7A;

    typedef struct {
        logic [7:0] data;
        logic       restart;
    } t_raw;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_max_body_size;

    hcbd_in_if  in_if ();
    hcbd_out_if out_if ();

    http_chunked_body_decoder dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in                (in_if),
        .o_out               (out_if),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_max_body_size (i_cfg_max_body_size)
    );

    // decoder state mirrored by the testbench
    logic [3:0]  dec_phase;
    logic        saw_cr;
    logic [31:0] chunk_left;
    logic [31:0] body_total;
    logic [31:0] body_limit;

    t_result decoded_q[$];
    t_raw    stream_q[$];
    t_result got_r;
    t_result want_r;
    logic    next_restart;
    int      items_sent;
    int      fail_count;
    int      cycles_run;
    int      idle_pct;
    int      stall_pct;

    always #5ns i_clk = ~i_clk;

    function automatic int digit_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
        if (b >= 8'h61 && b <= 8'h66) return b - 8'h57;
        if (b >= 8'h41 && b <= 8'h46) return b - 8'h37;
        return -1;
    endfunction

    function automatic logic blank_byte(input logic [7:0] b);
        return b == CHAR_SP || b == CHAR_TAB || b == CHAR_LF ||
               b == CHAR_VT || b == CHAR_FF || b == CHAR_CR;
    endfunction

    function automatic void add_digit(input int d);
        if (chunk_left > 32'h0FFF_FFFF) begin
            chunk_left = '1;
        end else begin
            chunk_left = {chunk_left[27:0], 4'(d)};
        end
    endfunction

    function automatic t_result decode_byte(input logic [7:0] b, input logic restart);
        t_result r;
        int      d;
        r = '0;
        r.status = ST_FRAME;
        if (restart) begin
            dec_phase  = PH_LEAD;
            saw_cr     = 1'b0;
            chunk_left = '0;
            body_total = '0;
        end
        case (dec_phase)
            PH_LEAD, PH_DIGITS, PH_EXT, PH_TRAILER: begin
                if (b == CHAR_LF && saw_cr) begin
                    saw_cr = 1'b0;
                    if (dec_phase == PH_TRAILER) begin
                        r.status  = ST_COMPLETE;
                        dec_phase = PH_DONE;
                    end else if (chunk_left == 0) begin
                        dec_phase = PH_TRAILER;
                    end else begin
                        dec_phase = PH_DATA;
                    end
                end else begin
                    saw_cr = (b == CHAR_CR);
                    d = digit_of(b);
                    if (dec_phase == PH_LEAD) begin
                        if (d >= 0) begin
                            add_digit(d);
                            dec_phase = PH_DIGITS;
                        end else if (!blank_byte(b)) begin
                            dec_phase = PH_EXT;
                        end
                    end else if (dec_phase == PH_DIGITS) begin
                        if (d >= 0) begin
                            add_digit(d);
                        end else begin
                            dec_phase = PH_EXT;
                        end
                    end
                end
            end
            PH_DATA: begin
                if (body_total != '1) body_total = body_total + 32'd1;
                if (chunk_left != 0) chunk_left = chunk_left - 32'd1;
                if (body_limit != 0 && body_total > body_limit) begin
                    r.status  = ST_TOOLARGE;
                    dec_phase = PH_TOOBIG;
                end else begin
                    r.status       = ST_PAYLOAD;
                    r.payload_byte = b;
                    if (chunk_left == 0) dec_phase = PH_SKIP1;
                end
            end
            PH_SKIP1: begin
                dec_phase = PH_SKIP2;
            end
            PH_SKIP2: begin
                dec_phase  = PH_LEAD;
                saw_cr     = 1'b0;
                chunk_left = '0;
            end
            default: begin
                r.status = ST_IGNORED;
            end
        endcase
        r.payload_total = body_total;
        return r;
    endfunction

    task automatic report_failure(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("mismatch %0d at %0t: %s expected %0h got %0h",
                     fail_count, $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_phase  = PH_LEAD;
            saw_cr     = 1'b0;
            chunk_left = '0;
            body_total = '0;
            body_limit = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) body_limit = i_cfg_max_body_size;
            if (in_if.valid && in_if.ready) begin
                decoded_q.push_back(decode_byte(in_if.data_byte, in_if.start_new));
            end
            if (out_if.valid && out_if.ready) begin
                got_r = {out_if.status, out_if.payload_byte, out_if.payload_total};
                if (decoded_q.size() == 0) begin
                    report_failure("unexpected transaction, status", '0,
                                   32'(got_r.status));
                end else begin
                    want_r = decoded_q.pop_front();
                    if (got_r.status !== want_r.status) begin
                        report_failure("status", 32'(want_r.status), 32'(got_r.status));
                    end
                    if (got_r.payload_byte !== want_r.payload_byte) begin
                        report_failure("payload_byte", 32'(want_r.payload_byte),
                                       32'(got_r.payload_byte));
                    end
                    if (got_r.payload_total !== want_r.payload_total) begin
                        report_failure("payload_total", want_r.payload_total,
                                       got_r.payload_total);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic send_byte(input t_raw item);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= item.data;
        in_if.start_new <= item.restart;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_queued();
        while (stream_q.size() != 0) send_byte(stream_q.pop_front());
    endtask

    function automatic void queue_item(input logic [7:0] b);
        stream_q.push_back('{data: b, restart: next_restart});
        next_restart = 1'b0;
    endfunction

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] limit);
        wait_for_results();
        i_cfg_valid         <= 1'b1;
        i_cfg_max_body_size <= limit;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'(CH_ZERO + v);
        return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    function automatic logic [7:0] printable_char();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(5))
            0: return CHAR_SP;
            1: return CHAR_TAB;
            2: return CHAR_LF;
            3: return CHAR_VT;
            4: return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(3))
            0: return CHAR_CR;
            1: return CHAR_LF;
            2: return hex_char($urandom_range(15));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void queue_line_end();
        queue_item(CHAR_CR);
        queue_item(CHAR_LF);
    endfunction

    // optional extension, sometimes with a lone cr inside
    function automatic void queue_extension();
        if ($urandom_range(3) == 0) begin
            queue_item(CH_SEMI);
            repeat ($urandom_range(0, 3)) queue_item(printable_char());
            if ($urandom_range(2) == 0) begin
                queue_item(CHAR_CR);
                queue_item(printable_char());
            end
        end
    endfunction

    task automatic queue_body();
        int chunk_len;
        next_restart = 1'b1;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 12)) queue_item(noise_char());
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(3) == 0) queue_item(blank_char());
            // oversized chunk: size saturates, body cut short
            if ($urandom_range(14) == 0) begin
                queue_item(hex_char($urandom_range(1, 15)));
                repeat (8) queue_item(hex_char($urandom_range(15)));
                queue_line_end();
                repeat ($urandom_range(0, 15)) queue_item(8'($urandom_range(255)));
                return;
            end
            chunk_len = $urandom_range(1, 24);
            if ($urandom_range(3) == 0) queue_item(CH_ZERO);
            if (chunk_len > 15) queue_item(hex_char(chunk_len >> 4));
            queue_item(hex_char(chunk_len & 15));
            queue_extension();
            queue_line_end();
            repeat (chunk_len) queue_item(8'($urandom_range(255)));
            if ($urandom_range(3) == 0) begin
                queue_item(8'($urandom_range(255)));
                queue_item(8'($urandom_range(255)));
            end else begin
                queue_line_end();
            end
            if ($urandom_range(19) == 0) return;
        end
        if ($urandom_range(3) == 0) queue_item(blank_char());
        case ($urandom_range(6))
            0: queue_item(CH_ZERO);
            1: repeat (3) queue_item(CH_ZERO);
            2: ;
            3: begin
                queue_item(CH_MINUS);
                queue_item(hex_char($urandom_range(1, 15)));
            end
            4: begin
                queue_item(CH_ZERO);
                queue_item($urandom_range(1) ? CH_X : 8'h58);
                queue_item(hex_char($urandom_range(1, 15)));
            end
            5: begin
                queue_item(CH_PLUS);
                queue_item(hex_char($urandom_range(1, 15)));
            end
            default: begin
                queue_item(CH_Z);
                queue_item(CH_Z);
            end
        endcase
        queue_extension();
        queue_line_end();
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 5)) queue_item(printable_char());
        end
        queue_line_end();
        repeat ($urandom_range(0, 2)) queue_item(8'($urandom_range(255)));
    endtask

    task automatic run_bodies(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            queue_body();
            send_queued();
        end
    endtask

    // blanks incl cr and lf, extension with lone cr, extreme data bytes, end and after end
    task automatic test_directed_body();
        idle_pct  = 0;
        stall_pct = 0;
        next_restart = 1'b1;
        queue_item(CHAR_SP);
        queue_item(CHAR_LF);
        queue_item(CHAR_TAB);
        queue_item(CHAR_VT);
        queue_item(CHAR_FF);
        queue_item(CHAR_CR);
        queue_item(8'h32);
        queue_item(CH_SEMI);
        queue_item(CHAR_CR);
        queue_item(CH_X);
        queue_line_end();
        queue_item(8'h00);
        queue_item(8'hFF);
        queue_item(8'h61);
        queue_item(8'h62);
        queue_item(CH_ZERO);
        queue_line_end();
        queue_line_end();
        queue_item(8'h41);
        send_queued();
    endtask

    task automatic test_no_limit();
        idle_pct  = 0;
        stall_pct = 0;
        write_limit('0);
        run_bodies(PHASE_ITEMS);
    endtask

    task automatic test_small_limits();
        idle_pct  = 65;
        stall_pct = 0;
        write_limit(32'd1);
        run_bodies(60);
        write_limit($urandom_range(2, 30));
        run_bodies(PHASE_ITEMS - 60);
    endtask

    task automatic test_full_limit();
        idle_pct  = 0;
        stall_pct = 65;
        write_limit('1);
        run_bodies(PHASE_ITEMS);
    endtask

    task automatic test_mixed_idling();
        idle_pct  = 16;
        stall_pct = 16;
        write_limit($urandom_range(10, 60));
        run_bodies(PHASE_ITEMS / 2);
        wait_for_results();
        run_bodies(PHASE_ITEMS - PHASE_ITEMS / 2);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_max_body_size = '0;
        in_if.valid         = 1'b0;
        in_if.data_byte     = '0;
        in_if.start_new     = 1'b0;
        out_if.ready        = 1'b0;
        idle_pct            = 0;
        stall_pct           = 0;
        next_restart        = 1'b1;
        items_sent          = 0;
        fail_count          = 0;
        cycles_run          = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_body();
        test_no_limit();
        test_small_limits();
        test_full_limit();
        test_mixed_idling();

        wait_for_results();
        fail_count += decoded_q.size();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/hcbd_pkg.sv
sv/hcbd_if.sv
sv/hcbd_core.sv
sv/hcbd_outbuf.sv
sv/http_chunked_body_decoder.sv
sim/tb_http_chunked_body_decoder.sv
